[hdl/assert_macros.svh]
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the page allocator RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[hdl/btpa_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// Buddy tree page allocator package
// Pool geometry, command and status codes, and the node unit interface.
// ============================================================================
package btpa_pkg;

    localparam int POOL_PAGES = 1024;
    localparam int LOG2_POOL  = 10;
    localparam int NODE_COUNT = 2 * POOL_PAGES - 1;
    localparam int IDX_W      = LOG2_POOL + 1;
    localparam int VAL_W      = LOG2_POOL + 1;
    localparam int CNT_W      = 11;
    localparam int OFS_W      = LOG2_POOL;
    localparam int SIZE_W     = CNT_W + 1;
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_BAD   = 2'd2
    } t_status;

    typedef struct packed {
        logic             free_mode;
        logic [VAL_W-1:0] cur;
        logic [VAL_W-1:0] sib;
        logic [VAL_W-1:0] parent_size;
        logic [VAL_W-1:0] probe;
        logic [VAL_W-1:0] need;
    } t_alu_in;

    typedef struct packed {
        logic [VAL_W-1:0] merged;
        logic             fits;
    } t_alu_out;

    // round a page count up to a power of two; counts above the pool give 2x pool
    function automatic logic [SIZE_W-1:0] round_pow2(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] m;
        logic [3:0]       pos;
        m   = cnt - CNT_W'(1);
        pos = 4'd0;
        if (cnt != '0) begin
            for (int i = 0; i < CNT_W; i++) begin
                if (m[i]) begin
                    pos = 4'(i + 1);
                end
            end
        end
        return SIZE_W'(1) << pos;
    endfunction

endpackage

[hdl/btpa_node_alu.sv]
`timescale 1ns / 1ps
// ============================================================================
// Buddy tree node unit
// Shared compare and merge unit: fit test during descent, parent refresh
// (max, or coalesce on free) during the walk back to the root.
// ============================================================================
module btpa_node_alu (
    input  btpa_pkg::t_alu_in  i_op,
    output btpa_pkg::t_alu_out o_res
);
    import btpa_pkg::*;

    logic [VAL_W:0]   w_sum;
    logic [VAL_W-1:0] w_max;

    always_comb begin
        w_sum = {1'b0, i_op.cur} + {1'b0, i_op.sib};
        w_max = (i_op.cur >= i_op.sib) ? i_op.cur : i_op.sib;
        if (i_op.free_mode && (w_sum == {1'b0, i_op.parent_size})) begin
            o_res.merged = i_op.parent_size;
        end else begin
            o_res.merged = w_max;
        end
        o_res.fits = (i_op.probe >= i_op.need);
    end

endmodule

[hdl/buddy_tree_page_allocator.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ============================================================================
// Buddy tree page allocator
// Binary buddy allocator over a 1024-page pool with a largest-free-below tree.
// ============================================================================
// A command is taken when start is high and busy is low; its single result
// appears for one cycle with o_result_valid and cannot be held off. The tree
// lives in a single-port-write, registered-read memory: each tree read is
// registered before use. An allocate reads down from the root to the node
// of its size, marks it and then refreshes the parents up to the root; a
// free climbs from its leaf to that node, checks that it is in use and
// refreshes the parents the same way. A command rejected on its fields
// answers in the next cycle without going busy; an allocate that does not
// fit is rejected once the root has been read, and a free of a block not
// in use once its node has been read. After reset and every init command,
// the block stays busy while it clears all 2047 nodes, one per cycle.
module buddy_tree_page_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [btpa_pkg::CMD_W-1:0]    i_command,
    input  logic [btpa_pkg::CNT_W-1:0]    i_page_count,
    input  logic [btpa_pkg::OFS_W-1:0]    i_page_offset,
    output logic                          o_result_valid,
    output logic [btpa_pkg::STAT_W-1:0]   o_status,
    output logic [btpa_pkg::OFS_W-1:0]    o_block_offset,
    output logic [btpa_pkg::CNT_W-1:0]    o_granted_pages,
    output logic [btpa_pkg::CNT_W-1:0]    o_avail_pages
);
    import btpa_pkg::*;

    typedef enum logic [11:0] {
        S_CLEAR   = 12'b0000_0000_0001,
        S_IDLE    = 12'b0000_0000_0010,
        S_A_ROOT  = 12'b0000_0000_0100,
        S_A_CHK   = 12'b0000_0000_1000,
        S_A_DN_RD = 12'b0000_0001_0000,
        S_A_DN_EV = 12'b0000_0010_0000,
        S_A_MARK  = 12'b0000_0100_0000,
        S_F_CLIMB = 12'b0000_1000_0000,
        S_F_CHK   = 12'b0001_0000_0000,
        S_UP_RD   = 12'b0010_0000_0000,
        S_UP_WR   = 12'b0100_0000_0000,
        S_FIN     = 12'b1000_0000_0000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic              r_report;
    logic              r_free_mode;
    logic [IDX_W-1:0]  r_idx;
    logic [VAL_W-1:0]  r_ns;
    logic [VAL_W-1:0]  r_size;
    logic [VAL_W-1:0]  r_cur;
    logic [OFS_W-1:0]  r_offs;
    logic [CNT_W-1:0]  r_free;

    logic              r_valid;
    t_status           r_status;
    logic [OFS_W-1:0]  r_out_offs;
    logic [CNT_W-1:0]  r_out_granted;
    logic [CNT_W-1:0]  r_out_free;

    logic [VAL_W-1:0]  r_tree [NODE_COUNT];
    logic [VAL_W-1:0]  r_rd_data;

    logic              w_accept;
    t_cmd              w_cmd;
    logic [SIZE_W-1:0] w_size;
    logic              w_size_big;
    logic              w_misaligned;
    logic              w_overrun;
    logic [IDX_W-1:0]  w_left;
    logic [IDX_W-1:0]  w_sibling;
    logic [IDX_W-1:0]  w_parent;
    logic [VAL_W-1:0]  w_half;
    logic [IDX_W:0]    w_next2;
    logic [IDX_W-1:0]  w_ra;
    logic [IDX_W-1:0]  w_wa;
    logic [VAL_W-1:0]  w_wd;
    logic              w_we;
    logic [CNT_W:0]    w_free_sum;
    logic [CNT_W-1:0]  w_free_after;
    t_alu_in           w_alu_in;
    t_alu_out          w_alu_out;
    logic              w_res_fail;
    logic              w_res_clear;
    logic              w_avail_ok;

    assign busy            = (r_state != S_IDLE);
    assign w_accept        = start && !busy;
    assign w_cmd           = t_cmd'(i_command);
    assign w_size          = round_pow2(i_page_count);
    assign w_size_big      = (w_size > SIZE_W'(POOL_PAGES));
    assign w_misaligned    = (({2'b00, i_page_offset} & (w_size - SIZE_W'(1))) != '0);
    assign w_overrun       = (({2'b00, i_page_offset} + w_size) > SIZE_W'(POOL_PAGES));
    assign w_left          = {r_idx[IDX_W-2:0], 1'b1};
    assign w_sibling       = r_idx[0] ? (r_idx + IDX_W'(1)) : (r_idx - IDX_W'(1));
    assign w_parent        = (r_idx - IDX_W'(1)) >> 1;
    assign w_half          = r_ns >> 1;
    assign w_next2         = {1'b0, r_idx} + (IDX_W + 1)'(2);
    assign w_free_sum      = {1'b0, r_free} + {1'b0, r_size};

    assign o_result_valid  = r_valid;
    assign o_status        = r_status;
    assign o_block_offset  = r_out_offs;
    assign o_granted_pages = r_out_granted;
    assign o_avail_pages   = r_out_free;

    assign w_res_fail      = o_result_valid && (o_status != ST_OK);
    assign w_res_clear     = (o_granted_pages == '0) && (o_block_offset == '0);
    assign w_avail_ok      = (o_avail_pages <= CNT_W'(POOL_PAGES));

    always_comb begin
        w_alu_in.free_mode   = r_free_mode;
        w_alu_in.cur         = r_cur;
        w_alu_in.sib         = r_rd_data;
        w_alu_in.parent_size = r_ns << 1;
        w_alu_in.probe       = r_rd_data;
        w_alu_in.need        = r_size;
    end

    btpa_node_alu u_alu (
        .i_op  (w_alu_in),
        .o_res (w_alu_out)
    );

    always_comb begin
        if (r_free_mode) begin
            w_free_after = (w_free_sum > (CNT_W + 1)'(POOL_PAGES)) ?
                           CNT_W'(POOL_PAGES) : w_free_sum[CNT_W-1:0];
        end else begin
            w_free_after = (r_free >= r_size) ? (r_free - r_size) : '0;
        end
    end

    always_comb begin
        w_ra = r_idx;
        w_we = 1'b0;
        w_wa = r_idx;
        w_wd = r_ns;
        unique case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
            end
            S_A_DN_RD: begin
                w_ra = w_left;
            end
            S_A_MARK: begin
                w_we = 1'b1;
                w_wd = '0;
            end
            S_F_CHK: begin
                w_we = (r_rd_data == '0);
            end
            S_UP_RD: begin
                w_ra = w_sibling;
            end
            S_UP_WR: begin
                w_we = 1'b1;
                w_wa = w_parent;
                w_wd = w_alu_out.merged;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_tree[w_wa] <= w_wd;
        end
        r_rd_data <= r_tree[w_ra];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_idx == IDX_W'(NODE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (w_cmd)
                        CMD_INIT: n_state = S_CLEAR;
                        CMD_ALLOC: begin
                            if (i_page_count != '0 && !w_size_big) begin
                                n_state = S_A_ROOT;
                            end
                        end
                        CMD_FREE: begin
                            if (i_page_count != '0 && !w_size_big && !w_misaligned &&
                                !w_overrun) begin
                                n_state = S_F_CLIMB;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_A_ROOT: n_state = S_A_CHK;
            S_A_CHK: begin
                if (!w_alu_out.fits) begin
                    n_state = S_IDLE;
                end else if (r_ns == r_size) begin
                    n_state = S_A_MARK;
                end else begin
                    n_state = S_A_DN_RD;
                end
            end
            S_A_DN_RD: n_state = S_A_DN_EV;
            S_A_DN_EV: n_state = (w_half == r_size) ? S_A_MARK : S_A_DN_RD;
            S_A_MARK:  n_state = (r_idx == '0) ? S_FIN : S_UP_RD;
            S_F_CLIMB: begin
                if (r_ns == r_size) begin
                    n_state = S_F_CHK;
                end
            end
            S_F_CHK: begin
                if (r_rd_data != '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = (r_idx == '0) ? S_FIN : S_UP_RD;
                end
            end
            S_UP_RD: n_state = S_UP_WR;
            S_UP_WR: n_state = (w_parent == '0) ? S_FIN : S_UP_RD;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_report    <= 1'b0;
            r_free_mode <= 1'b0;
            r_idx       <= '0;
            r_ns        <= VAL_W'(POOL_PAGES);
            r_free      <= CNT_W'(POOL_PAGES);
            r_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + IDX_W'(1);
                    if ((w_next2[IDX_W-1:0] & (r_idx + IDX_W'(1))) == '0) begin
                        r_ns <= w_half;
                    end
                    if (r_idx == IDX_W'(NODE_COUNT - 1)) begin
                        r_free <= CNT_W'(POOL_PAGES);
                        if (r_report) begin
                            r_valid       <= 1'b1;
                            r_status      <= ST_OK;
                            r_out_offs    <= '0;
                            r_out_granted <= '0;
                            r_out_free    <= CNT_W'(POOL_PAGES);
                        end
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_out_offs    <= '0;
                        r_out_granted <= '0;
                        r_out_free    <= r_free;
                        r_size        <= w_size[VAL_W-1:0];
                        r_offs        <= '0;
                        case (w_cmd)
                            CMD_INIT: begin
                                r_report <= 1'b1;
                                r_idx    <= '0;
                                r_ns     <= VAL_W'(POOL_PAGES);
                            end
                            CMD_ALLOC: begin
                                r_free_mode <= 1'b0;
                                r_idx       <= '0;
                                r_ns        <= VAL_W'(POOL_PAGES);
                                if (i_page_count == '0) begin
                                    r_valid  <= 1'b1;
                                    r_status <= ST_BAD;
                                end else if (w_size_big) begin
                                    r_valid  <= 1'b1;
                                    r_status <= ST_NOFIT;
                                end
                            end
                            CMD_FREE: begin
                                r_free_mode <= 1'b1;
                                r_idx       <= {1'b0, i_page_offset} + IDX_W'(POOL_PAGES - 1);
                                r_ns        <= VAL_W'(1);
                                if (i_page_count == '0 || w_size_big || w_misaligned ||
                                    w_overrun) begin
                                    r_valid  <= 1'b1;
                                    r_status <= ST_BAD;
                                end
                            end
                            default: begin
                                r_valid  <= 1'b1;
                                r_status <= ST_BAD;
                            end
                        endcase
                    end
                end
                S_A_ROOT: begin
                end
                S_A_CHK: begin
                    if (!w_alu_out.fits) begin
                        r_valid  <= 1'b1;
                        r_status <= ST_NOFIT;
                    end
                end
                S_A_DN_RD: begin
                end
                S_A_DN_EV: begin
                    r_ns <= w_half;
                    if (w_alu_out.fits) begin
                        r_idx <= w_left;
                    end else begin
                        r_idx  <= w_left + IDX_W'(1);
                        r_offs <= r_offs + w_half[OFS_W-1:0];
                    end
                end
                S_A_MARK: begin
                    r_cur <= '0;
                end
                S_F_CLIMB: begin
                    if (r_ns != r_size) begin
                        r_idx <= w_parent;
                        r_ns  <= r_ns << 1;
                    end
                end
                S_F_CHK: begin
                    r_cur <= r_ns;
                    if (r_rd_data != '0) begin
                        r_valid  <= 1'b1;
                        r_status <= ST_BAD;
                    end
                end
                S_UP_RD: begin
                end
                S_UP_WR: begin
                    r_cur <= w_alu_out.merged;
                    r_idx <= w_parent;
                    r_ns  <= r_ns << 1;
                end
                S_FIN: begin
                    r_free        <= w_free_after;
                    r_valid       <= 1'b1;
                    r_status      <= ST_OK;
                    r_out_offs    <= r_free_mode ? '0 : r_offs;
                    r_out_granted <= r_size;
                    r_out_free    <= w_free_after;
                end
                default: begin
                end
            endcase
        end
    end

    `ASSERT_IMPLY(a_result_when_idle, i_clk, i_rst_n, o_result_valid, !busy)
    `ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_result_valid)
    `ASSERT_IMPLY(a_free_bounded, i_clk, i_rst_n, o_result_valid, w_avail_ok)
    `ASSERT_IMPLY(a_fail_no_grant, i_clk, i_rst_n, w_res_fail, w_res_clear)

endmodule
